// ----- rtl/core/kdl_pkg.sv -----
`timescale 1ns / 1ps

package kdl_pkg;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        REG_KEY_ENABLE     = 2'd0,
        REG_DEBOUNCE_TICKS = 2'd1,
        REG_LED_INTERVAL   = 2'd2
    } t_reg_idx;

    localparam int unsigned CNT_W     = 8;
    localparam int unsigned PATTERN_W = 8;

    localparam logic [CNT_W-1:0] RST_DEBOUNCE_TICKS = 8'd20;
    localparam logic [CNT_W-1:0] RST_LED_INTERVAL   = 8'd100;

    typedef struct packed {
        logic             key_down;
        logic [CNT_W-1:0] press_total;
    } t_key_status;

    typedef struct packed {
        logic             led_on;
        logic [CNT_W-1:0] steps_left;
    } t_led_status;

endpackage

// ----- rtl/core/key_debounce_and_led_pattern_unit.sv -----
`timescale 1ns / 1ps
// Path from input item accepted to result item valid: input register, then state update,
// then the result is captured from the settled state into the output register.
// Throughput: one item per cycle while the output is not stalled; the state update is a single 9-bit add and compare.
// Reset: synchronous, active low; clears pipeline valids, all key/LED state,
// and loads register defaults (key enable 1, debounce 20, interval 100).
module key_debounce_and_led_pattern_unit
    import kdl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] pin_level, [8:1] load_pattern, [16:9] load_steps, [23:17] zero
    input  logic [23:0] s_axis_tdata,
    // [0] func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] key_down, [8:1] press_total, [9] led_on, [17:10] steps_left, [23:18] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    logic             r_key_enable;
    logic [CNT_W-1:0] r_debounce_ticks;
    logic [CNT_W-1:0] r_led_interval;

    logic                 r_in_valid;
    t_func                r_in_func;
    logic                 r_in_pin;
    logic [PATTERN_W-1:0] r_in_pattern;
    logic [CNT_W-1:0]     r_in_steps;

    logic        r_out_valid;
    logic [23:0] r_out_data;

    logic        out_free;
    logic        advance;
    logic        tick;
    logic        load;
    t_key_status key_status;
    t_led_status led_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_enable     <= 1'b1;
            r_debounce_ticks <= RST_DEBOUNCE_TICKS;
            r_led_interval   <= RST_LED_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_KEY_ENABLE:     r_key_enable     <= i_cfg_data[0];
                REG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data;
                REG_LED_INTERVAL:   r_led_interval   <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign tick          = advance && (r_in_func == FUNC_TICK);
    assign load          = advance && (r_in_func == FUNC_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func    <= t_func'(s_axis_tuser);
            r_in_pin     <= s_axis_tdata[0];
            r_in_pattern <= s_axis_tdata[8:1];
            r_in_steps   <= s_axis_tdata[16:9];
        end
    end

    kdl_key u_key (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (tick && r_key_enable),
        .i_pin_level      (r_in_pin),
        .i_debounce_ticks (r_debounce_ticks),
        .o_status         (key_status)
    );

    kdl_led u_led (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick),
        .i_load     (load),
        .i_pattern  (r_in_pattern),
        .i_steps    (r_in_steps),
        .i_interval (r_led_interval),
        .o_status   (led_status)
    );

    // state regs update at the same edge the stage advances, so r_res_pending marks the
    // result, which is captured from the settled state once the output is free
    logic r_res_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_pending <= 1'b0;
        end else if (advance) begin
            r_res_pending <= 1'b1;
        end else if (out_free) begin
            r_res_pending <= 1'b0;
        end
    end

    // r_res_pending can only be set while out_free, and it is drained whenever out_free;
    // advance is not gated by it, as the capture reads the settled state while a new item advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_res_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_res_pending) begin
            r_out_data <= {6'd0, led_status.steps_left, led_status.led_on,
                           key_status.press_total, key_status.key_down};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_press_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (key_status.press_total != $past(key_status.press_total))
        |-> (key_status.key_down && !$past(key_status.key_down)))
        else $error("press count moved without a debounced press");

    a_key_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (key_status.key_down != $past(key_status.key_down))
        |-> $past(tick && r_key_enable))
        else $error("debounced key changed without an enabled tick");

    a_steps_rise_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (led_status.steps_left > $past(led_status.steps_left))
        |-> $past(load))
        else $error("LED step count rose without a load item");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid)
        else $error("input stage item lost while output stalled");

endmodule

// ----- rtl/core/kdl_key.sv -----
`timescale 1ns / 1ps

module kdl_key
    import kdl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick,
    input  logic             i_pin_level,
    input  logic [CNT_W-1:0] i_debounce_ticks,
    output t_key_status      o_status
);

    logic [CNT_W-1:0] r_stable_timer, n_stable_timer;
    logic             r_prev_raw, n_prev_raw;
    logic             r_debounced, n_debounced;
    logic [CNT_W-1:0] r_press, n_press;
    logic             raw;
    logic [CNT_W:0]   timer_inc;

    // pin is active low
    assign raw       = ~i_pin_level;
    assign timer_inc = {1'b0, r_stable_timer} + {{CNT_W{1'b0}}, 1'b1};

    always_comb begin
        n_stable_timer = r_stable_timer;
        n_prev_raw     = r_prev_raw;
        n_debounced    = r_debounced;
        n_press        = r_press;
        if (i_tick) begin
            if (raw == r_prev_raw) begin
                if (timer_inc >= {1'b0, i_debounce_ticks}) begin
                    if (!r_debounced && raw) begin
                        n_press = r_press + {{(CNT_W-1){1'b0}}, 1'b1};
                    end
                    n_debounced    = raw;
                    n_stable_timer = i_debounce_ticks;
                end else begin
                    n_stable_timer = timer_inc[CNT_W-1:0];
                end
            end else begin
                n_stable_timer = '0;
                n_prev_raw     = raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_timer <= '0;
            r_prev_raw     <= 1'b0;
            r_debounced    <= 1'b0;
            r_press        <= '0;
        end else begin
            r_stable_timer <= n_stable_timer;
            r_prev_raw     <= n_prev_raw;
            r_debounced    <= n_debounced;
            r_press        <= n_press;
        end
    end

    assign o_status.key_down    = r_debounced;
    assign o_status.press_total = r_press;

endmodule

// ----- rtl/core/kdl_led.sv -----
`timescale 1ns / 1ps

module kdl_led
    import kdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic                 i_load,
    input  logic [PATTERN_W-1:0] i_pattern,
    input  logic [CNT_W-1:0]     i_steps,
    input  logic [CNT_W-1:0]     i_interval,
    output t_led_status          o_status
);

    logic [CNT_W-1:0]     r_step_timer, n_step_timer;
    logic [PATTERN_W-1:0] r_pattern, n_pattern;
    logic [CNT_W-1:0]     r_remaining, n_remaining;
    logic                 r_led, n_led;
    logic [CNT_W:0]       timer_inc;

    assign timer_inc = {1'b0, r_step_timer} + {{CNT_W{1'b0}}, 1'b1};

    always_comb begin
        n_step_timer = r_step_timer;
        n_pattern    = r_pattern;
        n_remaining  = r_remaining;
        n_led        = r_led;
        if (i_load) begin
            // timer untouched: a reload mid-play keeps the current interval
            n_pattern   = i_pattern;
            n_remaining = i_steps;
        end else if (i_tick) begin
            if (r_remaining != '0) begin
                if (timer_inc >= {1'b0, i_interval}) begin
                    n_step_timer = '0;
                    n_led        = r_pattern[0];
                    n_pattern    = {r_pattern[0], r_pattern[PATTERN_W-1:1]};
                    n_remaining  = r_remaining - {{(CNT_W-1){1'b0}}, 1'b1};
                end else begin
                    n_step_timer = timer_inc[CNT_W-1:0];
                end
            end else begin
                // idle: preset so the first step after a load fires at once
                n_step_timer = i_interval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_timer <= '0;
            r_pattern    <= '0;
            r_remaining  <= '0;
            r_led        <= 1'b0;
        end else begin
            r_step_timer <= n_step_timer;
            r_pattern    <= n_pattern;
            r_remaining  <= n_remaining;
            r_led        <= n_led;
        end
    end

    assign o_status.led_on     = r_led;
    assign o_status.steps_left = r_remaining;

endmodule
